### rtl/core/ipdq_pkg.sv
// Package for the interrupt priority dispatch queue: sizes, field widths,
// codes, payload structs and small helper functions.
// No dependencies.
package ipdq_pkg;

  localparam int LINE_COUNT  = 224;
  localparam int QUEUE_DEPTH = 256;

  localparam int IRQ_W      = 8;
  localparam int LEVEL_W    = 8;
  localparam int IRQ_CMP_W  = IRQ_W + 1;
  localparam int LINE_IDX_W = $clog2(LINE_COUNT);
  localparam int SLOT_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSTALL   = 2'd0,
    OP_UNINSTALL = 2'd1,
    OP_RAISE     = 2'd2,
    OP_DONE      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_UNCAUGHT   = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_DISPATCHED = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_DONE       = 3'd4,
    ST_UPDATED    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAISE_CHK,
    S_FREE_SCAN,
    S_DONE_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [IRQ_W-1:0]   irq;
    logic [LEVEL_W-1:0] level;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [IRQ_W-1:0] irq_out;
    logic             resend_valid;
    logic [IRQ_W-1:0] resend_irq;
  } out_t;

  // One scanned pending entry, as it leaves the lookup pipeline
  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot;
    logic [LEVEL_W-1:0] level;
    logic [IRQ_W-1:0]   line;
  } cand_t;

  typedef struct packed {
    logic              have;
    logic [SLOT_W-1:0] slot;
    logic [IRQ_W-1:0]  line;
  } best_t;

  function automatic logic line_in_range(input logic [IRQ_W-1:0] irq);
    return {1'b0, irq} < IRQ_CMP_W'(LINE_COUNT);
  endfunction

  function automatic logic [LINE_IDX_W-1:0] line_idx(input logic [IRQ_W-1:0] irq);
    return line_in_range(irq) ? irq[LINE_IDX_W-1:0] : '0;
  endfunction

endpackage

### rtl/core/ipdq_best_sel.sv
// Running best-candidate tracker for the handler-done scan: keeps the
// highest level seen, lowest slot on ties. Depends on ipdq_pkg.
module ipdq_best_sel (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           clr,
  input  ipdq_pkg::cand_t cand,
  output ipdq_pkg::best_t best
);

  logic                         have_r, have_nxt;
  logic [ipdq_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [ipdq_pkg::IRQ_W-1:0]   line_r, line_nxt;
  logic [ipdq_pkg::LEVEL_W-1:0] level_r, level_nxt;
  logic                         take;

  // strict compare keeps the earlier (lower) slot on equal levels
  assign take = cand.valid && (!have_r || (cand.level > level_r));

  always_comb begin
    have_nxt  = have_r;
    slot_nxt  = slot_r;
    line_nxt  = line_r;
    level_nxt = level_r;
    if (clr) begin
      have_nxt = 1'b0;
    end else if (take) begin
      have_nxt  = 1'b1;
      slot_nxt  = cand.slot;
      line_nxt  = cand.line;
      level_nxt = cand.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    line_r  <= line_nxt;
    level_r <= level_nxt;
  end

  assign best.have = have_r;
  assign best.slot = slot_r;
  assign best.line = line_r;

endmodule

### rtl/core/interrupt_priority_dispatch_queue.sv
// Interrupt priority dispatch queue top level. Uses ipdq_pkg and ipdq_best_sel.
// Line levels and queued lines live in two synchronous RAMs.
//
// One item at a time. A queued raise walks the pending valid bits from
// slot 0 for the lowest free one, and reports overflow when none is free.
// Handler done sweeps every pending slot through a three-stage lookup
// (pending-line RAM, then line-level RAM, then compare). A new item is
// taken while the previous result still waits in the output register.
// No clearing pass after reset.
module interrupt_priority_dispatch_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ipdq_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ipdq_pkg::out_t  out_data
);

  ipdq_pkg::state_t state_r, state_nxt;
  ipdq_pkg::in_t    item_r, item_nxt;
  ipdq_pkg::out_t   res_r, res_nxt;
  ipdq_pkg::out_t   out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic                                run_r, run_nxt;
  logic [ipdq_pkg::LEVEL_W-1:0]        run_lvl_r, run_lvl_nxt;
  logic [ipdq_pkg::LINE_COUNT-1:0]     line_present_r, line_present_nxt;
  logic [ipdq_pkg::QUEUE_DEPTH-1:0]    pend_valid_r, pend_valid_nxt;
  logic [ipdq_pkg::CNT_W-1:0]          scan_cnt_r, scan_cnt_nxt;

  // line level RAM
  logic [ipdq_pkg::LEVEL_W-1:0]    level_mem [ipdq_pkg::LINE_COUNT];
  logic                            level_we;
  logic [ipdq_pkg::LINE_IDX_W-1:0] level_waddr, level_raddr;
  logic [ipdq_pkg::LEVEL_W-1:0]    level_rdata_r;

  // pending line RAM
  logic [ipdq_pkg::IRQ_W-1:0]  pline_mem [ipdq_pkg::QUEUE_DEPTH];
  logic                        pline_we;
  logic [ipdq_pkg::SLOT_W-1:0] pline_raddr;
  logic [ipdq_pkg::IRQ_W-1:0]  pline_rdata_r;

  // scan lookup pipeline
  logic                        issue;
  logic                        p1_r, p1_tag_r;
  logic [ipdq_pkg::SLOT_W-1:0] p1_slot_r;
  logic                        p2_r, p2_tag_r, p2_inr_r;
  logic [ipdq_pkg::SLOT_W-1:0] p2_slot_r;
  logic [ipdq_pkg::IRQ_W-1:0]  p2_line_r;

  logic            best_clr;
  ipdq_pkg::cand_t cand;
  ipdq_pkg::best_t best;

  logic                        in_accept, out_load, drained;
  logic                        item_ok, queue_cond, slot_taken, scan_last;
  logic [ipdq_pkg::SLOT_W-1:0] scan_slot;

  assign in_stall  = (state_r != ipdq_pkg::S_IDLE);
  assign in_accept = in_valid && (state_r == ipdq_pkg::S_IDLE);
  assign out_load  = (state_r == ipdq_pkg::S_EMIT) && (!out_valid_r || !out_stall);
  assign drained   = !p1_r && !p2_r;

  assign item_ok    = ipdq_pkg::line_in_range(item_r.irq) &&
                      line_present_r[ipdq_pkg::line_idx(item_r.irq)];
  assign queue_cond = run_r && (run_lvl_r > level_rdata_r);
  assign scan_slot  = scan_cnt_r[ipdq_pkg::SLOT_W-1:0];
  assign scan_last  = (scan_cnt_r == ipdq_pkg::CNT_W'(ipdq_pkg::QUEUE_DEPTH - 1));
  assign slot_taken = pend_valid_r[scan_slot];

  assign level_waddr = ipdq_pkg::line_idx(in_data.irq);
  assign level_raddr = (state_r == ipdq_pkg::S_IDLE) ? ipdq_pkg::line_idx(in_data.irq)
                                                     : ipdq_pkg::line_idx(pline_rdata_r);
  assign pline_raddr = scan_slot;

  assign cand.valid = p2_r && p2_tag_r;
  assign cand.slot  = p2_slot_r;
  assign cand.line  = p2_line_r;
  assign cand.level = p2_inr_r ? level_rdata_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ipdq_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (in_data.op)
            ipdq_pkg::OP_INSTALL,
            ipdq_pkg::OP_UNINSTALL: state_nxt = ipdq_pkg::S_EMIT;
            ipdq_pkg::OP_RAISE:     state_nxt = ipdq_pkg::S_RAISE_CHK;
            ipdq_pkg::OP_DONE:      state_nxt = ipdq_pkg::S_DONE_SCAN;
            default:                state_nxt = ipdq_pkg::S_EMIT;
          endcase
        end
      end
      ipdq_pkg::S_RAISE_CHK: begin
        if (item_ok && queue_cond) begin
          state_nxt = ipdq_pkg::S_FREE_SCAN;
        end else begin
          state_nxt = ipdq_pkg::S_EMIT;
        end
      end
      ipdq_pkg::S_FREE_SCAN: begin
        if (!slot_taken || scan_last) begin
          state_nxt = ipdq_pkg::S_EMIT;
        end
      end
      ipdq_pkg::S_DONE_SCAN: begin
        if (scan_last) begin
          state_nxt = ipdq_pkg::S_DRAIN;
        end
      end
      ipdq_pkg::S_DRAIN: begin
        if (drained) begin
          state_nxt = ipdq_pkg::S_EMIT;
        end
      end
      ipdq_pkg::S_EMIT: begin
        if (out_load) begin
          state_nxt = ipdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = ipdq_pkg::S_IDLE;
    endcase
  end

  // datapath and table updates
  always_comb begin
    item_nxt         = item_r;
    res_nxt          = res_r;
    run_nxt          = run_r;
    run_lvl_nxt      = run_lvl_r;
    line_present_nxt = line_present_r;
    pend_valid_nxt   = pend_valid_r;
    scan_cnt_nxt     = scan_cnt_r;
    level_we         = 1'b0;
    pline_we         = 1'b0;
    issue            = 1'b0;
    best_clr         = 1'b0;
    unique case (state_r)
      ipdq_pkg::S_IDLE: begin
        if (in_accept) begin
          item_nxt             = in_data;
          res_nxt.status       = ipdq_pkg::ST_UPDATED;
          res_nxt.irq_out      = '0;
          res_nxt.resend_valid = 1'b0;
          res_nxt.resend_irq   = '0;
          unique case (in_data.op)
            ipdq_pkg::OP_INSTALL: begin
              if (ipdq_pkg::line_in_range(in_data.irq)) begin
                level_we = 1'b1;
                line_present_nxt[ipdq_pkg::line_idx(in_data.irq)] = 1'b1;
              end
            end
            ipdq_pkg::OP_UNINSTALL: begin
              if (ipdq_pkg::line_in_range(in_data.irq)) begin
                line_present_nxt[ipdq_pkg::line_idx(in_data.irq)] = 1'b0;
              end
            end
            ipdq_pkg::OP_RAISE: begin
              scan_cnt_nxt = '0;
            end
            ipdq_pkg::OP_DONE: begin
              run_nxt        = 1'b0;
              scan_cnt_nxt   = '0;
              best_clr       = 1'b1;
              res_nxt.status = ipdq_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
      end
      ipdq_pkg::S_RAISE_CHK: begin
        if (!item_ok) begin
          res_nxt.status = ipdq_pkg::ST_UNCAUGHT;
        end else if (!queue_cond) begin
          run_nxt         = 1'b1;
          run_lvl_nxt     = level_rdata_r;
          res_nxt.status  = ipdq_pkg::ST_DISPATCHED;
          res_nxt.irq_out = item_r.irq;
        end
      end
      ipdq_pkg::S_FREE_SCAN: begin
        if (!slot_taken) begin
          pend_valid_nxt[scan_slot] = 1'b1;
          pline_we        = 1'b1;
          res_nxt.status  = ipdq_pkg::ST_QUEUED;
          res_nxt.irq_out = item_r.irq;
        end else if (scan_last) begin
          res_nxt.status = ipdq_pkg::ST_OVERFLOW;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end
      ipdq_pkg::S_DONE_SCAN: begin
        issue        = 1'b1;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
      end
      ipdq_pkg::S_DRAIN: begin
        if (drained && best.have) begin
          pend_valid_nxt[best.slot] = 1'b0;
          res_nxt.resend_valid      = 1'b1;
          res_nxt.resend_irq        = best.line;
        end
      end
      ipdq_pkg::S_EMIT: ;
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ipdq_pkg::S_IDLE;
      out_valid_r    <= 1'b0;
      run_r          <= 1'b0;
      run_lvl_r      <= '0;
      line_present_r <= '0;
      pend_valid_r   <= '0;
      scan_cnt_r     <= '0;
      p1_r           <= 1'b0;
      p2_r           <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      run_r          <= run_nxt;
      run_lvl_r      <= run_lvl_nxt;
      line_present_r <= line_present_nxt;
      pend_valid_r   <= pend_valid_nxt;
      scan_cnt_r     <= scan_cnt_nxt;
      p1_r           <= issue;
      p2_r           <= p1_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    p1_tag_r   <= pend_valid_r[scan_slot];
    p1_slot_r  <= scan_slot;
    p2_tag_r   <= p1_tag_r;
    p2_slot_r  <= p1_slot_r;
    p2_line_r  <= pline_rdata_r;
    p2_inr_r   <= ipdq_pkg::line_in_range(pline_rdata_r);
  end

  always_ff @(posedge clk) begin
    if (level_we) begin
      level_mem[level_waddr] <= in_data.level;
    end
    level_rdata_r <= level_mem[level_raddr];
  end

  always_ff @(posedge clk) begin
    if (pline_we) begin
      pline_mem[scan_slot] <= item_r.irq;
    end
    pline_rdata_r <= pline_mem[pline_raddr];
  end

  ipdq_best_sel u_best_sel (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (best_clr),
    .cand  (cand),
    .best  (best)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // lookup pipeline only carries entries during the done sweep
  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p2_r |-> (state_r == ipdq_pkg::S_DONE_SCAN || state_r == ipdq_pkg::S_DRAIN))
    else $error("scan pipeline active outside done sweep");

  // a raise is only queued behind a running handler
  a_queue_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ipdq_pkg::S_FREE_SCAN) |-> run_r)
    else $error("free-slot search without running handler");

  a_dispatch_sets_run: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_data_r.status == ipdq_pkg::ST_DISPATCHED) |-> run_r)
    else $error("dispatched result without running handler");

  a_scan_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= ipdq_pkg::CNT_W'(ipdq_pkg::QUEUE_DEPTH))
    else $error("scan counter past queue depth");
`endif

endmodule
